### hdl/ctw_pkg.sv
// ctw_pkg: shared constants, types and helpers for the text console writer
// geometry, character codes, memory request and result structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int IDX_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int WORD_W = CHAR_W + ATTR_W;

  // tab stops
  localparam int TAB_STEP = 8;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  // attribute after reset
  localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h0F;

  // item modes
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // request to the cell memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  // finished result handed to the output stage
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scrolled;
  } result_t;

  // cell word: attribute in the high byte, character in the low byte
  function automatic logic [WORD_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] attr);
    make_cell = {attr, ch};
  endfunction

endpackage

`default_nettype wire

### hdl/ctw_cell_ram.sv
// ctw_cell_ram: generic single-port synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ctw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read, holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### hdl/ctw_ctrl.sv
// ctw_ctrl: cursor, row-base ring and memory sequencer of the text console
// drives the cell ram through a request struct, hands results to the output stage
// depends on ctw_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctw_ctrl import ctw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // input channel
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic              mode,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [IDX_W-1:0]  cell_index,
  // colour register
  input  wire logic              cfg_we,
  input  wire logic [ATTR_W-1:0] cfg_data,
  // cell memory
  output      mem_req_t          mem_req,
  input  wire logic [WORD_W-1:0] mem_rdata,
  // result hand-off
  output      result_t           res,
  input  wire logic              res_take
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_WRITE
  } state_t;

  state_t            state;
  logic [ATTR_W-1:0] text_color;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] fill_base;
  logic [COL_W-1:0]  fill_cnt;
  logic [ADDR_W-1:0] clr_cnt;
  logic [CHAR_W-1:0] ch_q;
  logic [ATTR_W-1:0] attr_q;
  logic              wr_en_q;
  logic [COL_W-1:0]  wr_col_q;
  logic [ROW_W-1:0]  wr_row_q;
  logic              rd_hit_q;
  logic              scrolled_q;

  logic              accept;
  logic [ROW_W-1:0]  step_row;
  logic [COL_W:0]    tab_col;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic              put_wr;
  logic              put_scroll;
  logic [COL_W-1:0]  wr_col;
  logic [ROW_W-1:0]  wr_row;
  logic [ADDR_W-1:0] base_next;
  logic              rd_hit;
  logic [ADDR_W:0]   rd_sum;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W:0]   wr_sum;
  logic [ADDR_W-1:0] wr_addr;

  // handshake
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // row step that saturates one past the bottom
  assign step_row = (row < ROW_W'(ROWS)) ? row + 1'b1 : row;

  // cursor update for a put
  always_comb begin
    tab_col    = ((COL_W + 1)'(col) + (COL_W + 1)'(TAB_STEP)) & ~((COL_W + 1)'(TAB_STEP - 1));
    put_col    = col;
    put_row    = row;
    put_wr     = 1'b0;
    put_scroll = 1'b0;
    wr_col     = col;
    wr_row     = row;
    priority if (char_code == CH_NEWLINE) begin
      put_col = '0;
      put_row = step_row;
    end else if (char_code == CH_RETURN) begin
      put_col = '0;
    end else if (char_code == CH_TAB) begin
      if (tab_col >= (COL_W + 1)'(COLUMNS)) begin
        put_col = '0;
        put_row = step_row;
      end else begin
        put_col = tab_col[COL_W-1:0];
      end
    end else begin
      // lazy wrap, then lazy scroll
      if (col >= COL_W'(COLUMNS)) begin
        wr_col = '0;
        wr_row = step_row;
      end
      if (wr_row >= ROW_W'(ROWS)) begin
        put_scroll = 1'b1;
        wr_row     = ROW_W'(ROWS - 1);
      end
      put_col = wr_col + 1'b1;
      put_row = wr_row;
      put_wr  = 1'b1;
    end
  end

  // ring of row bases: a scroll moves the top of the screen one row on
  assign base_next = (base == ADDR_W'(CELLS - COLUMNS)) ? '0 : base + ADDR_W'(COLUMNS);

  // read address through the ring
  assign rd_hit  = (cell_index < IDX_W'(CELLS));
  assign rd_sum  = (ADDR_W + 1)'(cell_index) + (ADDR_W + 1)'(base);
  assign rd_addr = (rd_sum >= (ADDR_W + 1)'(CELLS)) ?
                   ADDR_W'(rd_sum - (ADDR_W + 1)'(CELLS)) : ADDR_W'(rd_sum);

  // write address through the ring
  assign wr_sum  = (ADDR_W + 1)'(wr_row_q) * (ADDR_W + 1)'(COLUMNS)
                 + (ADDR_W + 1)'(wr_col_q) + (ADDR_W + 1)'(base);
  assign wr_addr = (wr_sum >= (ADDR_W + 1)'(CELLS)) ?
                   ADDR_W'(wr_sum - (ADDR_W + 1)'(CELLS)) : ADDR_W'(wr_sum);

  // memory requests
  always_comb begin
    mem_req = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_cnt;
        mem_req.wdata = make_cell(CH_SPACE, RESET_COLOR);
      end
      ST_IDLE: begin
        mem_req.re   = accept && (mode == MODE_READ) && rd_hit;
        mem_req.addr = rd_addr;
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = fill_base + ADDR_W'(fill_cnt);
        mem_req.wdata = make_cell(CH_SPACE, attr_q);
      end
      ST_WRITE: begin
        mem_req.we    = wr_en_q;
        mem_req.addr  = wr_addr;
        mem_req.wdata = make_cell(ch_q, attr_q);
      end
      ST_READ: begin
        mem_req = '0;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // result towards the output stage
  always_comb begin
    res          = '0;
    res.valid    = (state == ST_READ) || (state == ST_WRITE);
    res.word     = ((state == ST_READ) && rd_hit_q) ? mem_rdata : '0;
    res.col      = col;
    res.row      = row;
    res.scrolled = scrolled_q;
  end

  // sequencer, cursor and colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      text_color <= RESET_COLOR;
      col        <= '0;
      row        <= '0;
      base       <= '0;
      clr_cnt    <= '0;
      fill_cnt   <= '0;
      wr_en_q    <= 1'b0;
      rd_hit_q   <= 1'b0;
      scrolled_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_data;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (mode == MODE_READ) begin
              rd_hit_q   <= rd_hit;
              scrolled_q <= 1'b0;
              state      <= ST_READ;
            end else begin
              col        <= put_col;
              row        <= put_row;
              ch_q       <= char_code;
              attr_q     <= text_color;
              wr_en_q    <= put_wr;
              wr_col_q   <= wr_col;
              wr_row_q   <= wr_row;
              scrolled_q <= put_scroll;
              if (put_scroll) begin
                fill_base <= base;
                base      <= base_next;
                fill_cnt  <= '0;
                state     <= ST_FILL;
              end else begin
                state <= ST_WRITE;
              end
            end
          end
        end
        ST_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == COL_W'(COLUMNS - 1)) begin
            state <= ST_WRITE;
          end
        end
        ST_READ, ST_WRITE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // writes stay inside the cell store
  ap_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (mem_req.addr < ADDR_W'(CELLS)))
    else $error("cell write outside the store");

  // cursor never passes one beyond the screen
  ap_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (col <= COL_W'(COLUMNS)) && (row <= ROW_W'(ROWS)))
    else $error("cursor out of bounds");

  // a scrolling put goes through the fill of the new bottom row
  ap_scroll_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_PUT) && put_scroll) |=> (state == ST_FILL))
    else $error("scroll without row fill");

  // a result not yet taken holds its value
  ap_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res_take) |=> (res.valid && $stable(res.word) && $stable(res.col)
                                  && $stable(res.row) && $stable(res.scrolled)))
    else $error("pending result changed");

  // no reads while the scroll fill runs
  ap_no_read_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> !mem_req.re)
    else $error("read issued during row fill");

endmodule

`default_nettype wire

### hdl/text_console_writer_top.sv
// Flow: an accepted item waits in ST_READ or ST_WRITE of ctw_ctrl until the output
// register takes it; a put that scrolls first passes ST_FILL, the blank fill of the
// row it brings in. A new item is taken only in ST_IDLE, after the last one has
// gone to the output register; scrolling is a row-base ring, no copy.
// Reset: synchronous; afterwards a clearing pass blanks all CELLS (2000) cells
// while in_stall is high; colour register writes are taken as ever.
// text_console_writer_top: top level, cell ram, control and output register
// depends on ctw_pkg, ctw_cell_ram, ctw_ctrl
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top import ctw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // input channel
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic              mode,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [IDX_W-1:0]  cell_index,
  // colour register
  input  wire logic              cfg_we,
  input  wire logic [ATTR_W-1:0] cfg_data,
  // output channel
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [WORD_W-1:0] cell_word,
  output      logic [COL_W-1:0]  cursor_col,
  output      logic [ROW_W-1:0]  cursor_row,
  output      logic              scrolled
);

  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;
  result_t           res;
  logic              res_take;

  // cell store
  ctw_cell_ram #(
    .DEPTH (CELLS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  // cursor and sequencer
  ctw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .char_code  (char_code),
    .cell_index (cell_index),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .res        (res),
    .res_take   (res_take)
  );

  // output register loads when empty or when its transfer completes
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (res_take) begin
      cell_word  <= res.word;
      cursor_col <= res.col;
      cursor_row <= res.row;
      scrolled   <= res.scrolled;
    end
  end

endmodule

`default_nettype wire
